// ===== rtl/core/ria_pkg.sv =====
package ria_pkg;

  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_RELEASE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

endpackage

// ===== rtl/core/ria_if.sv =====
interface ria_req_if #(
  parameter int unsigned ID_BITS = 10
);
  logic               valid;
  logic               ready;
  ria_pkg::opcode_e   opcode;
  logic [ID_BITS-1:0] entity_id;

  modport source (output valid, output opcode, output entity_id, input ready);
  modport sink   (input valid, input opcode, input entity_id, output ready);
endinterface

interface ria_rsp_if #(
  parameter int unsigned ID_BITS = 10
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] result_id;
  ria_pkg::status_e   status;

  modport source (output valid, output result_id, output status, input ready);
  modport sink   (input valid, input result_id, input status, output ready);
endinterface

// ===== rtl/core/recycling_id_allocator_unit.sv =====
// Channel | Dir | Fields                     | Handshake
// req_i   | in  | opcode, entity_id          | valid / ready
// rsp_o   | out | result_id, status          | valid / ready
//
// In a transaction the accept edge reads the release queue and the
// free-mark memory; the edge that leaves S_EXEC updates both and loads the
// result register. Both memories have registered reads.
// After reset the free marks are swept clear, one entry a cycle, over all
// 2**ID_BITS entries (1024 by default) before the first request is taken.
// A full result register holds the update cycle until rsp_o takes it.
module recycling_id_allocator_unit #(
  parameter int unsigned ID_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ria_req_if.sink   req_i,
  ria_rsp_if.source rsp_o
);
  import ria_pkg::*;

  localparam longint unsigned IdSpace = 64'd1 << ID_BITS;
  localparam logic [ID_BITS-1:0] IdAllOnes = {ID_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ID_BITS-1:0] clr_q, clr_d;
  logic [ID_BITS-1:0] fresh_q, fresh_d;
  logic [ID_BITS-1:0] head_q, head_d;
  logic [ID_BITS-1:0] tail_q, tail_d;
  logic [ID_BITS:0]   count_q, count_d;

  opcode_e            op_q;
  logic [ID_BITS-1:0] id_q;

  logic [ID_BITS-1:0] queue_mem [IdSpace];
  logic               mark_mem  [IdSpace];
  logic [ID_BITS-1:0] queue_rdata_q;
  logic               mark_rdata_q;

  logic               queue_we;
  logic               mark_we;
  logic [ID_BITS-1:0] mark_waddr;
  logic               mark_wdata;

  logic               out_valid_q;
  logic [ID_BITS-1:0] out_id_q, out_id_d;
  status_e            out_status_q, out_status_d;

  logic               req_fire;
  logic               exec_fire;

  assign req_i.ready     = (state_q == S_IDLE);
  assign req_fire        = req_i.valid && req_i.ready;
  assign exec_fire       = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.result_id = out_id_q;
  assign rsp_o.status    = out_status_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    fresh_d      = fresh_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    queue_we     = 1'b0;
    mark_we      = 1'b0;
    mark_waddr   = clr_q;
    mark_wdata   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mark_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdAllOnes) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
          if (op_q == OP_ALLOCATE) begin
            if (count_q != '0) begin
              // reuse the oldest released ID
              out_id_d     = queue_rdata_q;
              out_status_d = ST_ALLOCATED;
              head_d       = head_q + 1'b1;
              count_d      = count_q - 1'b1;
              mark_we      = 1'b1;
              mark_waddr   = queue_rdata_q;
              mark_wdata   = 1'b0;
            end else if (fresh_q == IdAllOnes) begin
              out_id_d     = '0;
              out_status_d = ST_EXHAUSTED;
            end else begin
              out_id_d     = fresh_q;
              out_status_d = ST_ALLOCATED;
              fresh_d      = fresh_q + 1'b1;
            end
          end else begin
            out_id_d = id_q;
            if (mark_rdata_q || count_q[ID_BITS]) begin
              out_status_d = ST_IGNORED;
            end else begin
              out_status_d = ST_RELEASED;
              queue_we     = 1'b1;
              tail_d       = tail_q + 1'b1;
              count_d      = count_q + 1'b1;
              mark_we      = 1'b1;
              mark_waddr   = id_q;
              mark_wdata   = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fresh_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: capture the request, load the result
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req_i.opcode;
      id_q <= req_i.entity_id;
    end
    if (exec_fire) begin
      out_id_q     <= out_id_d;
      out_status_q <= out_status_d;
    end
  end

  // release queue memory
  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[tail_q] <= id_q;
    end
    if (req_fire) begin
      queue_rdata_q <= queue_mem[head_q];
    end
  end

  // free-mark memory
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (req_fire) begin
      mark_rdata_q <= mark_mem[req_i.entity_id];
    end
  end

endmodule
